FILE: hdl/aee_pkg.sv
package aee_pkg;

  // Field widths
  localparam int CHANNEL_W = 4;
  localparam int LEVEL_W   = 8;
  localparam int RATE_W    = 8;
  localparam int MVOL_W    = 4;
  localparam int PHASE_W   = 3;
  localparam int REQ_W     = 2;
  localparam int OP_W      = 3;
  localparam int STEP_W    = 2;

  // Request codes on req_type
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_START = 2'd1;
  localparam logic [REQ_W-1:0] REQ_STOP  = 2'd2;

  // Classified operations handed from front to back
  localparam logic [OP_W-1:0] OP_NONE  = 3'd0;  // channel out of range
  localparam logic [OP_W-1:0] OP_TICK  = 3'd1;
  localparam logic [OP_W-1:0] OP_START = 3'd2;
  localparam logic [OP_W-1:0] OP_STOP  = 3'd3;
  localparam logic [OP_W-1:0] OP_PEEK  = 3'd4;  // unused request code, report only

  // Reported phase codes
  localparam logic [PHASE_W-1:0] PHASE_OFF     = 3'd0;
  localparam logic [PHASE_W-1:0] PHASE_PENDING = 3'd1;
  localparam logic [PHASE_W-1:0] PHASE_ATTACK  = 3'd2;
  localparam logic [PHASE_W-1:0] PHASE_DECAY   = 3'd3;
  localparam logic [PHASE_W-1:0] PHASE_SUSTAIN = 3'd4;
  localparam logic [PHASE_W-1:0] PHASE_RELEASE = 3'd5;
  localparam logic [PHASE_W-1:0] PHASE_ECHO    = 3'd6;

  // Envelope step field
  localparam logic [STEP_W-1:0] STEP_ATTACK  = 2'd3;
  localparam logic [STEP_W-1:0] STEP_DECAY   = 2'd2;
  localparam logic [STEP_W-1:0] STEP_SUSTAIN = 2'd1;
  localparam logic [STEP_W-1:0] STEP_NONE    = 2'd0;

  localparam logic [MVOL_W-1:0]  MVOL_RESET = 4'hF;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 8'hFF;

  // Per-channel phase flags
  typedef struct packed {
    logic              start;
    logic              stop;
    logic              loop;
    logic              echo;
    logic [STEP_W-1:0] step;
  } flags_t;

  // Classified command in the middle queue
  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [CHANNEL_W-1:0] channel;
    logic [RATE_W-1:0]    atk_rate;
    logic [RATE_W-1:0]    dec_rate;
    logic [LEVEL_W-1:0]   sus_level;
    logic [RATE_W-1:0]    rel_rate;
    logic [LEVEL_W-1:0]   echo_lvl;
    logic                 loop_en;
  } cmd_t;

  // Channel status after the state update
  typedef struct packed {
    logic [CHANNEL_W-1:0] channel;
    logic [LEVEL_W-1:0]   level;
    logic                 active;
    logic [PHASE_W-1:0]   phase;
    logic                 loop;
  } stat_t;

  // Result item in the output queue
  typedef struct packed {
    logic [CHANNEL_W-1:0] channel;
    logic [LEVEL_W-1:0]   level;
    logic [LEVEL_W-1:0]   mix;
    logic                 active;
    logic [PHASE_W-1:0]   phase;
    logic                 loop;
  } res_t;

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(res_t);

  // Channel sounds or waits to start
  function automatic logic is_live(input flags_t f);
    return f.start | f.stop | f.echo | (f.step != STEP_NONE);
  endfunction

  function automatic logic [PHASE_W-1:0] phase_code(input flags_t f);
    logic [PHASE_W-1:0] p;
    priority if (!is_live(f)) p = PHASE_OFF;
    else if (f.start)         p = PHASE_PENDING;
    else if (f.echo)          p = PHASE_ECHO;
    else if (f.stop)          p = PHASE_RELEASE;
    else if (f.step == STEP_ATTACK) p = PHASE_ATTACK;
    else if (f.step == STEP_DECAY)  p = PHASE_DECAY;
    else                      p = PHASE_SUSTAIN;
    return p;
  endfunction

endpackage

FILE: hdl/aee_fifo.sv
module aee_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/aee_front.sv
module aee_front import aee_pkg::*; #(
  parameter int NUM_CHANNELS = 16
) (
  input  logic [REQ_W-1:0]     req_type,
  input  logic [CHANNEL_W-1:0] channel,
  input  logic [RATE_W-1:0]    attack_rate,
  input  logic [RATE_W-1:0]    decay_rate,
  input  logic [LEVEL_W-1:0]   sustain_level,
  input  logic [RATE_W-1:0]    release_rate,
  input  logic [LEVEL_W-1:0]   echo_level,
  input  logic                 loop_enable,
  output cmd_t                 cmd
);

  // Classify the request and range-check the channel
  always_comb begin
    cmd.channel   = channel;
    cmd.atk_rate  = attack_rate;
    cmd.dec_rate  = decay_rate;
    cmd.sus_level = sustain_level;
    cmd.rel_rate  = release_rate;
    cmd.echo_lvl  = echo_level;
    cmd.loop_en   = loop_enable;
    if (int'(channel) >= NUM_CHANNELS) begin
      cmd.op = OP_NONE;
    end else begin
      unique case (req_type)
        REQ_TICK:  cmd.op = OP_TICK;
        REQ_START: cmd.op = OP_START;
        REQ_STOP:  cmd.op = OP_STOP;
        default:   cmd.op = OP_PEEK;
      endcase
    end
  end

endmodule

FILE: hdl/aee_back.sv
module aee_back import aee_pkg::*; #(
  parameter int NUM_CHANNELS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  input  logic              cmd_valid,
  output logic              cmd_pop,
  input  logic [MVOL_W-1:0] master_volume,
  input  logic              res_full,
  output logic              res_push,
  output res_t              res
);

  // Only channels reachable by the channel field get storage
  localparam int NUM_STORED = (NUM_CHANNELS < (1 << CHANNEL_W)) ? NUM_CHANNELS
                                                               : (1 << CHANNEL_W);
  localparam int IDX_W = (NUM_STORED > 1) ? $clog2(NUM_STORED) : 1;

  flags_t             flags_mem [NUM_STORED];
  logic [LEVEL_W-1:0] level_mem [NUM_STORED];
  logic [LEVEL_W-1:0] echo_mem  [NUM_STORED];
  logic [RATE_W-1:0]  atk_mem   [NUM_STORED];
  logic [RATE_W-1:0]  dec_mem   [NUM_STORED];
  logic [LEVEL_W-1:0] sus_mem   [NUM_STORED];
  logic [RATE_W-1:0]  rel_mem   [NUM_STORED];

  logic [IDX_W-1:0]     idx;
  flags_t               f;
  flags_t               flags_next;
  logic [LEVEL_W-1:0]   lvl;
  logic [LEVEL_W-1:0]   level_next;
  logic [LEVEL_W-1:0]   ech;
  logic [LEVEL_W-1:0]   echo_next;
  logic [RATE_W-1:0]    mul_rate;
  logic [2*LEVEL_W-1:0] prod;
  logic [LEVEL_W-1:0]   scaled;
  logic [LEVEL_W:0]     atk_sum;
  logic                 act;
  logic                 fire;
  logic                 wr_state;
  stat_t                stat;
  stat_t                b_stat;
  logic                 b_valid;
  logic [MVOL_W:0]      mv_inc;
  logic [LEVEL_W+MVOL_W:0] mix_prod;

  // Stage handshake: stage B drains into the result queue
  assign res_push = b_valid && !res_full;
  assign fire     = cmd_valid && (!b_valid || !res_full);
  assign cmd_pop  = fire;
  assign wr_state = fire && (cmd.op != OP_NONE);

  // Channel state read
  assign idx = cmd.channel[IDX_W-1:0];
  assign f   = flags_mem[idx];
  assign lvl = level_mem[idx];
  assign ech = echo_mem[idx];

  // Shared decay/release multiplier and attack adder
  assign mul_rate = f.stop ? rel_mem[idx] : dec_mem[idx];
  assign prod     = lvl * mul_rate;
  assign scaled   = prod[2*LEVEL_W-1:LEVEL_W];
  assign atk_sum  = {1'b0, lvl} + {1'b0, atk_mem[idx]};

  // Per-channel envelope update
  always_comb begin
    flags_next = f;
    level_next = lvl;
    echo_next  = ech;
    act        = is_live(f);
    unique case (cmd.op)
      OP_TICK: begin
        if (is_live(f)) begin
          priority if (f.start) begin
            if (f.stop) begin
              // stop while pending cancels the note
              flags_next = '0;
              act        = 1'b0;
            end else begin
              flags_next      = '0;
              flags_next.loop = f.loop;
              flags_next.step = STEP_ATTACK;
              level_next      = atk_mem[idx];
            end
          end else if (f.echo) begin
            echo_next = ech - 1'b1;
            if (echo_next == '0) begin
              flags_next = '0;
              act        = 1'b0;
            end
          end else if (f.stop) begin
            level_next = scaled;
            if (scaled <= ech) begin
              if (ech == '0) begin
                flags_next = '0;
                act        = 1'b0;
              end else begin
                flags_next.echo = 1'b1;
              end
            end
          end else begin
            unique case (f.step)
              STEP_DECAY: begin
                level_next = scaled;
                if (scaled <= sus_mem[idx]) begin
                  if (sus_mem[idx] == '0) begin
                    // no sustain: fall through to the echo tail
                    if (ech == '0) begin
                      flags_next = '0;
                      act        = 1'b0;
                    end else begin
                      flags_next.echo = 1'b1;
                    end
                  end else begin
                    level_next      = sus_mem[idx];
                    flags_next.step = STEP_SUSTAIN;
                  end
                end
              end
              STEP_ATTACK: begin
                if (atk_sum[LEVEL_W]) begin
                  level_next      = LEVEL_MAX;
                  flags_next.step = STEP_DECAY;
                end else begin
                  level_next = atk_sum[LEVEL_W-1:0];
                end
              end
              default: begin
                flags_next = f;
              end
            endcase
          end
        end
      end
      OP_START: begin
        flags_next       = '0;
        flags_next.start = 1'b1;
        flags_next.loop  = cmd.loop_en;
        echo_next        = cmd.echo_lvl;
        act              = 1'b1;
      end
      OP_STOP: begin
        if (is_live(f)) begin
          flags_next.stop = 1'b1;
        end
      end
      default: begin
        flags_next = f;
      end
    endcase
  end

  // Status for the result
  always_comb begin
    stat.channel = cmd.channel;
    if (cmd.op == OP_NONE) begin
      stat.level  = '0;
      stat.active = 1'b0;
      stat.phase  = PHASE_OFF;
      stat.loop   = 1'b0;
    end else begin
      stat.level  = level_next;
      stat.active = act;
      stat.phase  = phase_code(flags_next);
      stat.loop   = flags_next.loop;
    end
  end

  // Channel state write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_STORED; i++) begin
        flags_mem[i] <= '0;
        level_mem[i] <= '0;
        echo_mem[i]  <= '0;
      end
    end else if (wr_state) begin
      flags_mem[idx] <= flags_next;
      level_mem[idx] <= level_next;
      echo_mem[idx]  <= echo_next;
    end
  end

  // Rates, undefined until a start writes them
  always_ff @(posedge clk) begin
    if (fire && (cmd.op == OP_START)) begin
      atk_mem[idx] <= cmd.atk_rate;
      dec_mem[idx] <= cmd.dec_rate;
      sus_mem[idx] <= cmd.sus_level;
      rel_mem[idx] <= cmd.rel_rate;
    end
  end

  // Stage B register
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (fire) begin
      b_valid <= 1'b1;
    end else if (res_push) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      b_stat <= stat;
    end
  end

  // Mix scaling: level * (master + 1) / 16
  assign mv_inc   = {1'b0, master_volume} + 1'b1;
  assign mix_prod = (LEVEL_W + MVOL_W + 1)'(b_stat.level) * (LEVEL_W + MVOL_W + 1)'(mv_inc);

  always_comb begin
    res.channel = b_stat.channel;
    res.level   = b_stat.level;
    res.mix     = mix_prod[LEVEL_W+MVOL_W-1:MVOL_W];
    res.active  = b_stat.active;
    res.phase   = b_stat.phase;
    res.loop    = b_stat.loop;
  end

endmodule

FILE: hdl/adsr_echo_envelope.sv
// A transfer passes the command queue, the stage B register and the result queue.
// Throughput: one item per cycle while the result queue is not full, including
//   repeated ticks on the same channel; the state update closes as the item pops.
// Queues of four entries sit before the state stage and after the mix stage.
// Reset (rst, synchronous): queues empty, all channels off with level and echo
//   zero, master volume 15; channel rates are left as they are until a start.
module adsr_echo_envelope import aee_pkg::*; #(
  parameter int NUM_CHANNELS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [REQ_W-1:0]     req_type,
  input  logic [CHANNEL_W-1:0] channel,
  input  logic [RATE_W-1:0]    attack_rate,
  input  logic [RATE_W-1:0]    decay_rate,
  input  logic [LEVEL_W-1:0]   sustain_level,
  input  logic [RATE_W-1:0]    release_rate,
  input  logic [LEVEL_W-1:0]   echo_level,
  input  logic                 loop_enable,
  output logic                 empty,
  input  logic                 pop,
  output logic [CHANNEL_W-1:0] out_channel,
  output logic [LEVEL_W-1:0]   envelope_level,
  output logic [LEVEL_W-1:0]   mix_level,
  output logic                 active,
  output logic [PHASE_W-1:0]   phase,
  output logic                 loop_flag,
  input  logic                 cfg_wr_en,
  input  logic [MVOL_W-1:0]    cfg_wr_data
);

  localparam int QUEUE_DEPTH = 4;

  cmd_t              front_cmd;
  logic [CMD_W-1:0]  mid_rdata;
  cmd_t              mid_cmd;
  logic              mid_empty;
  logic              mid_pop;
  logic              res_full;
  logic              res_push;
  res_t              back_res;
  logic [RES_W-1:0]  out_rdata;
  res_t              out_res;
  logic [MVOL_W-1:0] master_volume;

  // Master volume register
  always_ff @(posedge clk) begin
    if (rst) begin
      master_volume <= MVOL_RESET;
    end else if (cfg_wr_en) begin
      master_volume <= cfg_wr_data;
    end
  end

  aee_front #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .req_type     (req_type),
    .channel      (channel),
    .attack_rate  (attack_rate),
    .decay_rate   (decay_rate),
    .sustain_level(sustain_level),
    .release_rate (release_rate),
    .echo_level   (echo_level),
    .loop_enable  (loop_enable),
    .cmd          (front_cmd)
  );

  // Command queue between front and back
  aee_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata(front_cmd),
    .full (full),
    .pop  (mid_pop),
    .rdata(mid_rdata),
    .empty(mid_empty)
  );

  assign mid_cmd = cmd_t'(mid_rdata);

  aee_back #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd          (mid_cmd),
    .cmd_valid    (!mid_empty),
    .cmd_pop      (mid_pop),
    .master_volume(master_volume),
    .res_full     (res_full),
    .res_push     (res_push),
    .res          (back_res)
  );

  // Result queue
  aee_fifo #(
    .WIDTH(RES_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .wdata(back_res),
    .full (res_full),
    .pop  (pop),
    .rdata(out_rdata),
    .empty(empty)
  );

  assign out_res        = res_t'(out_rdata);
  assign out_channel    = out_res.channel;
  assign envelope_level = out_res.level;
  assign mix_level      = out_res.mix;
  assign active         = out_res.active;
  assign phase          = out_res.phase;
  assign loop_flag      = out_res.loop;

endmodule

FILE: hdl/aee_checker.sv
module aee_checker import aee_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 push,
  input logic                 full,
  input logic                 empty,
  input logic                 pop,
  input logic [CHANNEL_W-1:0] out_channel,
  input logic [LEVEL_W-1:0]   envelope_level,
  input logic [LEVEL_W-1:0]   mix_level,
  input logic                 active,
  input logic [PHASE_W-1:0]   phase,
  input logic                 loop_flag
);

  logic [3:0] outstanding;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = push && !full;
  assign out_xfer = pop && !empty;

  // Items accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else if (in_xfer && !out_xfer) begin
      outstanding <= outstanding + 1'b1;
    end else if (out_xfer && !in_xfer) begin
      outstanding <= outstanding - 1'b1;
    end
  end

  // No result appears without an item behind it
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    (outstanding == '0) |-> empty)
    else $error("result shown with no item outstanding");

  // Active exactly when the channel is not off
  a_active_phase: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (active == (phase != PHASE_OFF)))
    else $error("active flag disagrees with phase");

  // Mix never exceeds the envelope level
  a_mix_bound: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (mix_level <= envelope_level))
    else $error("mix level above envelope level");

  // A waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_channel) && $stable(envelope_level)
      && $stable(mix_level) && $stable(active) && $stable(phase) && $stable(loop_flag)))
    else $error("waiting result changed before transfer");

endmodule

bind adsr_echo_envelope aee_checker u_aee_checker (.*);
